### rtl/core/byte_ring_buffer_unit_macros.svh
// Assertion macros used by the top level of the byte ring buffer RTL.
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring buffer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring buffer: next-cycle check failed");

`endif

### rtl/core/brb_pkg.sv
// Package with the types and constants of the byte ring buffer.
package brb_pkg;

    localparam int SLOT_COUNT_DEF       = 1024;
    localparam int DEFAULT_CAPACITY_DEF = 1023;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 10;
    localparam int RUN_W  = 11;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE     = 3'd0,
        OP_DEQUEUE     = 3'd1,
        OP_PEEK        = 3'd2,
        OP_WRITE_AHEAD = 3'd3,
        OP_MOVE_REAR   = 3'd4,
        OP_MOVE_FRONT  = 3'd5,
        OP_CLEAR       = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EXEC,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic exec;
        logic report;
    } t_cmd;

endpackage

### rtl/core/brb_ctrl.sv
// Sequencer that steps one transaction through evaluate, execute and report.
module brb_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    output logic        o_done,
    output brb_pkg::t_cmd o_cmd
);
    import brb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_REPORT);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL:   n_state = S_EXEC;
            S_EXEC:   n_state = S_REPORT;
            S_REPORT: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.report = (r_state == S_REPORT);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### rtl/core/brb_datapath.sv
// Pointers, capacity register, byte store and result registers of the ring buffer.
module brb_datapath #(
    parameter int SLOT_COUNT       = brb_pkg::SLOT_COUNT_DEF,
    parameter int DEFAULT_CAPACITY = brb_pkg::DEFAULT_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brb_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic [brb_pkg::OP_W-1:0]    i_op,
    input  logic [brb_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic [brb_pkg::CNT_W-1:0]   i_amount,
    output logic [brb_pkg::BYTE_W-1:0]  o_byte_out,
    output logic                        o_ok,
    output logic [brb_pkg::CNT_W-1:0]   o_used_count,
    output logic [brb_pkg::CNT_W-1:0]   o_free_count,
    output logic [brb_pkg::RUN_W-1:0]   o_contiguous_write,
    output logic [brb_pkg::RUN_W-1:0]   o_contiguous_read
);
    import brb_pkg::*;

    localparam int PW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW = (PW >= RUN_W) ? PW + 1 : RUN_W + 1;
    localparam logic [AW-1:0] MAX_CAP = AW'(SLOT_COUNT - 1);
    // The default is saturated to the ring size before it is narrowed.
    localparam logic [AW-1:0] DEF_CAP =
        (DEFAULT_CAPACITY > SLOT_COUNT - 1) ? MAX_CAP : AW'(DEFAULT_CAPACITY);
    localparam logic [AW-1:0] RST_CAP =
        (DEFAULT_CAPACITY == 0) ? AW'(1) :
        (DEFAULT_CAPACITY > SLOT_COUNT - 1) ? MAX_CAP : DEF_CAP;

    logic [BYTE_W-1:0] mem [SLOT_COUNT];

    logic [AW-1:0]     r_cap;
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_tail;
    t_op               r_op;
    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_amt;
    logic [AW-1:0]     r_used;
    logic [AW-1:0]     r_free;
    logic [AW-1:0]     r_head_off;
    logic [AW-1:0]     r_tail_off;
    logic [AW-1:0]     r_head_inc;
    logic [AW-1:0]     r_tail_inc;
    logic              r_ok;
    logic              r_rd_sel;
    logic [BYTE_W-1:0] r_rd;

    function automatic logic [AW-1:0] advance(
        input logic [AW-1:0] pos,
        input logic [AW-1:0] step,
        input logic [AW-1:0] slots
    );
        logic [AW-1:0] p;
        p = pos + step;
        if (p >= slots) begin
            p = p - slots;
        end
        return p;
    endfunction

    logic [AW-1:0] slots;
    logic [AW-1:0] head_x;
    logic [AW-1:0] tail_x;
    logic [AW-1:0] amt_x;
    logic [AW-1:0] used;
    logic [AW-1:0] cap_clamped;
    logic [AW-1:0] cap_raw;

    assign slots  = r_cap + AW'(1);
    assign head_x = AW'(r_head);
    assign tail_x = AW'(r_tail);
    assign amt_x  = AW'(r_amt);
    assign used   = (tail_x >= head_x) ? (tail_x - head_x) : (slots - head_x + tail_x);

    // Zero loads the default, oversized values saturate to the ring size.
    assign cap_raw = AW'(i_cfg_wdata);
    always_comb begin
        cap_clamped = (cap_raw == '0) ? DEF_CAP : cap_raw;
        if (cap_clamped > MAX_CAP) begin
            cap_clamped = MAX_CAP;
        end
        if (cap_clamped == '0) begin
            cap_clamped = AW'(1);
        end
    end

    // Execute-stage decision.
    logic          ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_sel;
    logic [AW-1:0] head_nx;
    logic [AW-1:0] tail_nx;

    always_comb begin
        ok      = 1'b0;
        wr_en   = 1'b0;
        wr_addr = tail_x;
        rd_addr = head_x;
        rd_sel  = 1'b0;
        head_nx = head_x;
        tail_nx = tail_x;
        unique case (r_op)
            OP_ENQUEUE: begin
                ok = (r_free != '0);
                wr_en = ok;
                if (ok) tail_nx = r_tail_inc;
            end
            OP_DEQUEUE: begin
                ok = (r_used != '0);
                rd_sel = ok;
                if (ok) head_nx = r_head_inc;
            end
            OP_PEEK: begin
                ok = (amt_x < r_used);
                rd_sel = ok;
                rd_addr = r_head_off;
            end
            OP_WRITE_AHEAD: begin
                ok = (amt_x < r_free);
                wr_en = ok;
                wr_addr = r_tail_off;
            end
            OP_MOVE_REAR: begin
                ok = (amt_x != '0) && (amt_x <= r_free);
                if (ok) tail_nx = r_tail_off;
            end
            OP_MOVE_FRONT: begin
                ok = (amt_x != '0) && (amt_x <= r_used);
                if (ok) head_nx = r_head_off;
            end
            OP_CLEAR: begin
                ok = 1'b1;
                head_nx = '0;
                tail_nx = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= RST_CAP;
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cfg_we) begin
            r_cap  <= cap_clamped;
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.exec) begin
            r_head <= head_nx[PW-1:0];
            r_tail <= tail_nx[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_byte <= i_byte_in;
            r_amt  <= i_amount;
        end
        if (i_cmd.eval) begin
            r_used     <= used;
            r_free     <= r_cap - used;
            r_head_off <= advance(head_x, amt_x, slots);
            r_tail_off <= advance(tail_x, amt_x, slots);
            r_head_inc <= advance(head_x, AW'(1), slots);
            r_tail_inc <= advance(tail_x, AW'(1), slots);
        end
        if (i_cmd.exec) begin
            r_ok     <= ok;
            r_rd_sel <= rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (wr_en) begin
                mem[wr_addr[PW-1:0]] <= r_byte;
            end
            r_rd <= mem[rd_addr[PW-1:0]];
        end
    end

    // Report stage: occupancy and runs from the updated pointers.
    logic [AW-1:0] cw;
    logic [AW-1:0] cr;

    always_comb begin
        if (head_x > tail_x) begin
            cw = head_x - tail_x - AW'(1);
            cr = slots - head_x;
        end else begin
            cw = (head_x == '0) ? (slots - tail_x - AW'(1)) : (slots - tail_x);
            cr = tail_x - head_x;
        end
    end

    logic [AW-1:0] free_now;
    assign free_now = r_cap - used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            o_byte_out         <= r_rd_sel ? r_rd : '0;
            o_ok               <= r_ok;
            o_used_count       <= used[CNT_W-1:0];
            o_free_count       <= free_now[CNT_W-1:0];
            o_contiguous_write <= cw[RUN_W-1:0];
            o_contiguous_read  <= cr[RUN_W-1:0];
        end
    end

endmodule

### rtl/core/byte_ring_buffer_unit.sv
// Top level of the byte ring buffer: sequencer plus datapath.
//
// The byte ring buffer keeps up to capacity bytes in a circular store of
// capacity+1 slots. A transaction is accepted on a rising edge with i_start
// high and o_busy low; o_busy then stays high through evaluate, execute and
// report, and the result appears on the output ports with o_done high for
// exactly one cycle right after that, at which point a new transaction may
// already be started. The receiver cannot stall results, so they must be
// captured in that cycle. The sequencer sets the steps: evaluate forms counts
// and offsets from the pointers, execute does the registered byte store access
// and pointer update, and report computes the reported counts. Writing the
// capacity register (only while idle) also clears both pointers; zero loads
// the default capacity.
`include "byte_ring_buffer_unit_macros.svh"

module byte_ring_buffer_unit #(
    parameter int SLOT_COUNT       = brb_pkg::SLOT_COUNT_DEF,
    parameter int DEFAULT_CAPACITY = brb_pkg::DEFAULT_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    output logic                        o_done,
    input  logic                        i_cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic [brb_pkg::OP_W-1:0]    i_op,
    input  logic [brb_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic [brb_pkg::CNT_W-1:0]   i_amount,
    output logic [brb_pkg::BYTE_W-1:0]  o_byte_out,
    output logic                        o_ok,
    output logic [brb_pkg::CNT_W-1:0]   o_used_count,
    output logic [brb_pkg::CNT_W-1:0]   o_free_count,
    output logic [brb_pkg::RUN_W-1:0]   o_contiguous_write,
    output logic [brb_pkg::RUN_W-1:0]   o_contiguous_read
);
    import brb_pkg::*;

    t_cmd cmd;

    // The sequencer only issues stage strobes; it never looks at data.
    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    brb_datapath #(
        .SLOT_COUNT       (SLOT_COUNT),
        .DEFAULT_CAPACITY (DEFAULT_CAPACITY)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_op               (i_op),
        .i_byte_in          (i_byte_in),
        .i_amount           (i_amount),
        .o_byte_out         (o_byte_out),
        .o_ok               (o_ok),
        .o_used_count       (o_used_count),
        .o_free_count       (o_free_count),
        .o_contiguous_write (o_contiguous_write),
        .o_contiguous_read  (o_contiguous_read)
    );

    // A result is only shown once the sequencer has returned to idle.
    `BRB_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_done, !o_busy)
    // An accepted transaction makes the block busy on the next cycle.
    `BRB_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // A refused operation never returns a byte.
    `BRB_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, o_done && !o_ok, o_byte_out == '0)
    // Accepting a transaction cannot produce a result in the following cycle.
    `BRB_ASSERT_NXT(a_no_early_done, i_clk, i_rst_n, i_start && !o_busy, !o_done)

endmodule

### sim/testbench.sv
// Self-checking testbench for the byte ring buffer unit: stimulus, prediction and scoreboard.
`timescale 1ns / 1ps

module testbench;
    import brb_pkg::*;

    // Op code 7 is not part of the enum; the block must refuse it and change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Generous ceiling on the run, which has about 1300 transactions.
    localparam int CYCLE_LIMIT = 200000;

    // One command as it is applied to the block.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  amount;
    } t_command;

    // One result as the block reports it.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              ok;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  room;
        logic [RUN_W-1:0]  write_run;
        logic [RUN_W-1:0]  read_run;
    } t_outcome;

    // All block inputs start at known values; reset is held from time zero.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_start     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic [OP_W-1:0]   i_op        = '0;
    logic [BYTE_W-1:0] i_byte_in   = '0;
    logic [CNT_W-1:0]  i_amount    = '0;

    logic              o_busy;
    logic              o_done;
    logic [BYTE_W-1:0] o_byte_out;
    logic              o_ok;
    logic [CNT_W-1:0]  o_used_count;
    logic [CNT_W-1:0]  o_free_count;
    logic [RUN_W-1:0]  o_contiguous_write;
    logic [RUN_W-1:0]  o_contiguous_read;

    byte_ring_buffer_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .o_done             (o_done),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_op               (i_op),
        .i_byte_in          (i_byte_in),
        .i_amount           (i_amount),
        .o_byte_out         (o_byte_out),
        .o_ok               (o_ok),
        .o_used_count       (o_used_count),
        .o_free_count       (o_free_count),
        .o_contiguous_write (o_contiguous_write),
        .o_contiguous_read  (o_contiguous_read)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the ring. It is updated when a transaction is accepted,
    // so it always reflects every command the block has taken so far.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]       ring_bytes [SLOT_COUNT_DEF];
    bit [SLOT_COUNT_DEF-1:0] ring_filled = '0;   // slots that have ever been written
    int                      ring_head   = 0;
    int                      ring_tail   = 0;
    int                      ring_cap    = DEFAULT_CAPACITY_DEF;

    t_command commands_waiting [$];   // commands not yet offered to the block
    t_outcome results_due [$];        // predicted results, oldest first
    t_command cmd_in_hand;            // command currently offered on the ports
    bit       holding      = 1'b0;
    int       idle_pct     = 26;      // chance of starting a hold-off, in percent
    int       hold_left    = 0;
    int       burst_len    = 0;       // write-ahead burst being generated
    int       burst_pos    = 0;
    int       error_count  = 0;
    int       cycle_count  = 0;

    function automatic int ring_used();
        if (ring_tail >= ring_head) begin
            return ring_tail - ring_head;
        end
        return ring_cap + 1 - ring_head + ring_tail;
    endfunction

    // Position step places after pos, wrapped once around the ring.
    function automatic int ring_step(input int pos, input int step);
        int p;
        p = pos + step;
        if (p >= ring_cap + 1) begin
            p -= ring_cap + 1;
        end
        return p;
    endfunction

    // Applies one accepted command to the shadow ring and forms its result.
    task automatic ring_apply(input t_command c, output t_outcome r);
        int used;
        int room;
        int slots;
        int pos;
        used  = ring_used();
        room  = ring_cap - used;
        slots = ring_cap + 1;
        r     = '0;
        case (c.op)
            OP_ENQUEUE: begin
                if (room != 0) begin
                    ring_bytes[ring_tail]  = c.data;
                    ring_filled[ring_tail] = 1'b1;
                    ring_tail = ring_step(ring_tail, 1);
                    r.ok = 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (used != 0) begin
                    r.byte_out = ring_bytes[ring_head];
                    ring_head  = ring_step(ring_head, 1);
                    r.ok = 1'b1;
                end
            end
            OP_PEEK: begin
                if (c.amount < used) begin
                    r.byte_out = ring_bytes[ring_step(ring_head, c.amount)];
                    r.ok = 1'b1;
                end
            end
            OP_WRITE_AHEAD: begin
                // Lands beyond the rear without committing it.
                if (c.amount < room) begin
                    pos = ring_step(ring_tail, c.amount);
                    ring_bytes[pos]  = c.data;
                    ring_filled[pos] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            OP_MOVE_REAR: begin
                if (c.amount != 0 && c.amount <= room) begin
                    ring_tail = ring_step(ring_tail, c.amount);
                    r.ok = 1'b1;
                end
            end
            OP_MOVE_FRONT: begin
                if (c.amount != 0 && c.amount <= used) begin
                    ring_head = ring_step(ring_head, c.amount);
                    r.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                // Positions reset; the stored bytes stay where they are.
                ring_head = 0;
                ring_tail = 0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase

        used   = ring_used();
        r.used = CNT_W'(used);
        r.room = CNT_W'(ring_cap - used);

        // The write run stops at the physical end or one short of the head.
        if (ring_head > ring_tail) begin
            r.write_run = RUN_W'(ring_head - ring_tail - 1);
        end else if (ring_head == 0) begin
            r.write_run = RUN_W'(slots - ring_tail - 1);
        end else begin
            r.write_run = RUN_W'(slots - ring_tail);
        end

        if (ring_head > ring_tail) begin
            r.read_run = RUN_W'(slots - ring_head);
        end else begin
            r.read_run = RUN_W'(ring_tail - ring_head);
        end
    endtask

    // Step for a move command: mostly a legal step, otherwise one of the edges
    // around the legal range or any value at all.
    function automatic logic [CNT_W-1:0] pick_step(input int span);
        int k;
        k = $urandom_range(9);
        if (k < 7 && span > 0) begin
            return CNT_W'($urandom_range(span, 1));
        end else if (k == 7) begin
            return '0;
        end else if (k == 8) begin
            return (span + 1 > 1023) ? CNT_W'(span) : CNT_W'(span + 1);
        end
        return CNT_W'($urandom_range(1023));
    endfunction

    // Builds the next random command from the current ring state. Most are
    // well-formed; write-ahead bursts followed by a move of the rear over them
    // model the way a producer fills the ring in place.
    task automatic make_command(output t_command c);
        int used;
        int room;
        int pick;
        used     = ring_used();
        room     = ring_cap - used;
        pick     = $urandom_range(99);
        c.op     = OP_ENQUEUE;
        c.data   = BYTE_W'($urandom_range(255));
        c.amount = CNT_W'($urandom_range(1023));

        if (burst_len != 0) begin
            if (burst_pos < burst_len) begin
                c.op     = OP_WRITE_AHEAD;
                c.amount = CNT_W'(burst_pos);
                burst_pos++;
            end else begin
                c.op      = OP_MOVE_REAR;
                c.amount  = CNT_W'(burst_len);
                burst_len = 0;
            end
        end else if (pick < 10 && room > 0) begin
            burst_len = $urandom_range((room < 8) ? room : 8, 1);
            burst_pos = 1;
            c.op      = OP_WRITE_AHEAD;
            c.amount  = '0;
        end else if (pick < 38) begin
            c.op = OP_ENQUEUE;
        end else if (pick < 58) begin
            c.op = OP_DEQUEUE;
        end else if (pick < 68) begin
            c.op = OP_PEEK;
            if (used > 0 && $urandom_range(3) != 0) begin
                c.amount = CNT_W'($urandom_range(used - 1));
            end else if ($urandom_range(1) == 1) begin
                c.amount = CNT_W'(used);
            end
        end else if (pick < 75) begin
            c.op = OP_WRITE_AHEAD;
            if (room > 0 && $urandom_range(3) != 0) begin
                c.amount = CNT_W'($urandom_range(room - 1));
            end else if ($urandom_range(1) == 1) begin
                c.amount = CNT_W'(room);
            end
        end else if (pick < 83) begin
            c.op     = OP_MOVE_REAR;
            c.amount = pick_step(room);
        end else if (pick < 91) begin
            c.op     = OP_MOVE_FRONT;
            c.amount = pick_step(used);
        end else if (pick < 94) begin
            c.op = OP_CLEAR;
        end else if (pick < 97) begin
            c.op = OP_UNUSED;
        end else begin
            c.op = OP_W'($urandom_range(OP_UNUSED));
        end

        // A slot committed by moving the rear may never have been written;
        // reading it has no defined value, so skip over it instead.
        if ((c.op == OP_DEQUEUE && used > 0 && !ring_filled[ring_head]) ||
            (c.op == OP_PEEK && c.amount < used &&
             !ring_filled[ring_step(ring_head, c.amount)])) begin
            c.op     = OP_MOVE_FRONT;
            c.amount = CNT_W'(1);
        end
    endtask

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver. A transaction is accepted at an edge where i_start is high and
    // o_busy is low; both are sampled before this edge's updates land. The
    // command is predicted at that moment, and i_start gets exactly one
    // assignment per edge so that back-to-back commands keep it high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_outcome r;
        logic     offer;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            offer = i_start;
            if (i_start && !o_busy) begin
                ring_apply(cmd_in_hand, r);
                results_due.push_back(r);
                holding = 1'b0;
                offer   = 1'b0;
            end
            if (!offer && commands_waiting.size() != 0) begin
                // Hold-offs of random length let the gaps land on every
                // phase of the block's transaction sequence.
                if (hold_left != 0) begin
                    hold_left--;
                end else if ($urandom_range(99) < idle_pct) begin
                    hold_left = $urandom_range(5);
                end else begin
                    cmd_in_hand = commands_waiting.pop_front();
                    holding     = 1'b1;
                    offer       = 1'b1;
                    i_op        <= cmd_in_hand.op;
                    i_byte_in   <= cmd_in_hand.data;
                    i_amount    <= cmd_in_hand.amount;
                end
            end
            i_start <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. The result is valid for exactly one cycle with o_done high and
    // cannot be held off, so it is checked at the edge that ends that cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_outcome e;
        if (i_rst_n && o_done === 1'b1) begin
            if (results_due.size() == 0) begin
                report_error("result reported with no transaction outstanding");
            end else begin
                e = results_due.pop_front();
                if (o_byte_out !== e.byte_out)
                    report_error($sformatf("byte_out %0h, expected %0h",
                                           o_byte_out, e.byte_out));
                if (o_ok !== e.ok)
                    report_error($sformatf("ok %0b, expected %0b", o_ok, e.ok));
                if (o_used_count !== e.used)
                    report_error($sformatf("used_count %0d, expected %0d",
                                           o_used_count, e.used));
                if (o_free_count !== e.room)
                    report_error($sformatf("free_count %0d, expected %0d",
                                           o_free_count, e.room));
                if (o_contiguous_write !== e.write_run)
                    report_error($sformatf("contiguous_write %0d, expected %0d",
                                           o_contiguous_write, e.write_run));
                if (o_contiguous_read !== e.read_run)
                    report_error($sformatf("contiguous_read %0d, expected %0d",
                                           o_contiguous_read, e.read_run));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [OP_W-1:0] op, input int data, input int amount);
        t_command c;
        c.op     = op;
        c.data   = BYTE_W'(data);
        c.amount = CNT_W'(amount);
        commands_waiting.push_back(c);
    endtask

    // Returns once every command has been accepted and answered.
    task automatic wait_drained();
        while (commands_waiting.size() != 0 || holding || results_due.size() != 0 ||
               o_busy !== 1'b0) begin
            @(negedge i_clk);
        end
    endtask

    // Capacity is only written while the block is idle. Any write also
    // clears both positions, and zero loads the default capacity.
    task automatic write_capacity(input int value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        ring_cap  = (value == 0) ? DEFAULT_CAPACITY_DEF :
                    (value > SLOT_COUNT_DEF - 1) ? SLOT_COUNT_DEF - 1 : value;
        ring_head = 0;
        ring_tail = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random commands are made one at a time, only once the previous one has
    // been accepted, so that each is shaped by the true ring state.
    task automatic run_random(input int count, input int pct);
        t_command c;
        idle_pct  = pct;
        burst_len = 0;
        burst_pos = 0;
        repeat (count) begin
            while (commands_waiting.size() != 0 || holding) begin
                @(negedge i_clk);
            end
            make_command(c);
            commands_waiting.push_back(c);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset capacity: extremes of the fields, a full
        // ring reached by moving the rear, refusals on both sides, the
        // unused op code and clear.
        queue_cmd(OP_ENQUEUE,     8'h00, 0);
        queue_cmd(OP_ENQUEUE,     8'hFF, 1023);
        queue_cmd(OP_PEEK,        0,     1);
        queue_cmd(OP_PEEK,        0,     2);      // offset equal to used: refused
        queue_cmd(OP_WRITE_AHEAD, 8'hA5, 1020);   // last free slot
        queue_cmd(OP_WRITE_AHEAD, 8'h5A, 1021);   // offset equal to free: refused
        queue_cmd(OP_MOVE_REAR,   0,     1022);   // step above free: refused
        queue_cmd(OP_MOVE_REAR,   0,     1021);   // ring becomes full
        queue_cmd(OP_ENQUEUE,     8'h5A, 0);      // full: refused
        queue_cmd(OP_MOVE_FRONT,  0,     0);      // zero step: refused
        queue_cmd(OP_DEQUEUE,     0,     0);
        queue_cmd(OP_MOVE_FRONT,  0,     1022);   // ring becomes empty
        queue_cmd(OP_DEQUEUE,     0,     0);      // empty: refused
        queue_cmd(OP_UNUSED,      8'hFF, 1023);
        queue_cmd(OP_CLEAR,       0,     0);

        // Directed, on a tiny ring: fill, refuse, wrap the rear past the end.
        write_capacity(3);
        queue_cmd(OP_ENQUEUE,     8'h11, 0);
        queue_cmd(OP_ENQUEUE,     8'h22, 0);
        queue_cmd(OP_ENQUEUE,     8'h33, 0);
        queue_cmd(OP_ENQUEUE,     8'h44, 0);      // full: refused
        queue_cmd(OP_DEQUEUE,     0,     0);
        queue_cmd(OP_WRITE_AHEAD, 8'h55, 0);
        queue_cmd(OP_MOVE_REAR,   0,     1);      // rear wraps to slot zero
        queue_cmd(OP_PEEK,        0,     2);
        queue_cmd(OP_MOVE_FRONT,  0,     4);      // above used: refused
        queue_cmd(OP_MOVE_FRONT,  0,     3);

        // Random phases across the capacity range, smallest and largest
        // included; one phase offers commands with no hold-offs at all.
        write_capacity(1);
        run_random(150, 26);
        write_capacity(0);
        run_random(250, 26);
        write_capacity(1023);
        run_random(200, 0);
        write_capacity(2);
        run_random(150, 26);
        write_capacity($urandom_range(40, 4));
        run_random(250, 26);
        write_capacity(9);
        run_random(250, 26);

        // Let the last result arrive, then keep the clock running so that any
        // stray result can still show up.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
